// File: hdl/manowar_julia_escape_iteration_core_assert.svh
// Assertion macros shared by the escape-iteration core RTL.
`ifndef MANOWAR_JULIA_ESCAPE_ITERATION_CORE_ASSERT_SVH
`define MANOWAR_JULIA_ESCAPE_ITERATION_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define MJEI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, sampled on aclk, off while in reset
`define MJEI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: hdl/mjei_pkg.sv
// Shared types, constants and helpers for the escape-iteration core.
package mjei_pkg;

    // Fixed-point format and widths
    localparam int COORD_W    = 32;
    localparam int FRAC_W     = 27;
    localparam int ITER_W     = 16;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int SUM_W      = PROD_W - FRAC_W + 3;
    localparam int NORM_SHIFT = 2 * FRAC_W + 2;

    // Configuration port
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = ADDR_W - 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [COORD_W-1:0] mag_t;
    typedef logic        [PROD_W-1:0]  prod_t;
    typedef logic        [ITER_W-1:0]  iter_t;
    typedef logic signed [SUM_W-1:0]   wsum_t;

    // Operand pair handed to the shared multiplier
    typedef struct packed {
        mag_t op_a;
        mag_t op_b;
    } mul_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_RR,
        ST_MUL_II,
        ST_MUL_RI,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_K_REAL   = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_K_IMAG   = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = REG_IDX_W'(2);

    localparam iter_t MAX_ITER_RST = ITER_W'(256);

    // |z|^2 escape bound: 4.0 in the squared format
    localparam logic [PROD_W:0] NORM_LIMIT = (PROD_W + 1)'(1) << NORM_SHIFT;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

    // Absolute value; the most negative code maps to 2^(COORD_W-1)
    function automatic mag_t mag_of(coord_t v);
        mag_t u;
        u = mag_t'(v);
        return v[COORD_W-1] ? (~u + mag_t'(1)) : u;
    endfunction

    // Sign-extend a coordinate to the sum width
    function automatic wsum_t widen(coord_t v);
        return {{(SUM_W - COORD_W){v[COORD_W-1]}}, v};
    endfunction

    // Saturate a wide sum to the coordinate range
    function automatic coord_t clamp(wsum_t x);
        logic fits;
        fits = (&x[SUM_W-1:COORD_W-1]) || (~|x[SUM_W-1:COORD_W-1]);
        if (fits) begin
            return x[COORD_W-1:0];
        end
        return x[SUM_W-1] ? COORD_MIN : COORD_MAX;
    endfunction

endpackage

// File: hdl/mjei_mult.sv
// Shared registered unsigned multiplier used for all squares and cross products.
module mjei_mult (
    input  logic              aclk,
    input  mjei_pkg::mul_op_t mul_op,
    output mjei_pkg::prod_t   product
);
    import mjei_pkg::*;

    prod_t product_reg;

    // One product per cycle, registered
    always_ff @(posedge aclk) begin
        product_reg <= PROD_W'(mul_op.op_a) * PROD_W'(mul_op.op_b);
    end

    assign product = product_reg;

endmodule

// File: hdl/manowar_julia_escape_iteration_core.sv
// Top level: Manowar-Julia escape-time core with APB registers and sequencer.
//
//  Channel  Direction  Handshake        Payload
//  s_       in         s_valid/s_ready  s_pixel_re, s_pixel_im (Q5.27)
//  m_       out        m_valid/m_ready  m_iteration_count, m_inside_set,
//                                       m_escape_re, m_escape_im
//  APB      in         psel/penable     paddr, pwdata, prdata (k_real, k_imag, max_iter)
//
// Each recurrence step runs a check state, then re^2, im^2 and re*im through the one
// shared 32x32 multiplier, then an update state for the add and norm compare.
// s_ready is high only while idle.
// The result sits in an output register; the core goes idle once it is loaded, so a
// new request is accepted while the previous result still waits on m_ready.
// aresetn is synchronous, active low; it clears the sequencer, counter and valid.
`include "manowar_julia_escape_iteration_core_assert.svh"

module manowar_julia_escape_iteration_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input requests
    input  logic                             s_valid,
    output logic                             s_ready,
    input  mjei_pkg::coord_t                 s_pixel_re,
    input  mjei_pkg::coord_t                 s_pixel_im,
    // results
    output logic                             m_valid,
    input  logic                             m_ready,
    output mjei_pkg::iter_t                  m_iteration_count,
    output logic                             m_inside_set,
    output mjei_pkg::coord_t                 m_escape_re,
    output mjei_pkg::coord_t                 m_escape_im,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mjei_pkg::ADDR_W-1:0]      paddr,
    input  logic [mjei_pkg::DATA_W-1:0]      pwdata,
    output logic [mjei_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import mjei_pkg::*;

    // Configuration registers
    coord_t k_real_reg;
    coord_t k_imag_reg;
    iter_t  max_iter_reg;

    // Sequencer and iteration state
    state_t state_reg;
    state_t state_next;
    coord_t z_re_reg;
    coord_t z_im_reg;
    coord_t prior_re_reg;
    coord_t prior_im_reg;
    mag_t   mag_re_reg;
    mag_t   mag_im_reg;
    prod_t  rr_reg;
    prod_t  ii_reg;
    iter_t  step_cnt_reg;
    logic   inside_reg;

    // Result register
    logic   m_valid_reg;
    iter_t  m_count_reg;
    logic   m_inside_reg;
    coord_t m_escape_re_reg;
    coord_t m_escape_im_reg;

    // Shared multiplier
    mul_op_t mul_op;
    prod_t   product;

    // Step datapath
    logic [PROD_W:0]   norm;
    logic              escaped;
    wsum_t             re_part;
    wsum_t             im_abs;
    wsum_t             im_part;
    wsum_t             sum_re;
    wsum_t             sum_im;
    logic              out_load;
    logic [REG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_real_reg   <= '0;
            k_imag_reg   <= '0;
            max_iter_reg <= MAX_ITER_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_K_REAL:   k_real_reg   <= pwdata[COORD_W-1:0];
                REG_K_IMAG:   k_imag_reg   <= pwdata[COORD_W-1:0];
                REG_MAX_ITER: max_iter_reg <= pwdata[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            REG_K_REAL:   prdata = DATA_W'(mag_t'(k_real_reg));
            REG_K_IMAG:   prdata = DATA_W'(mag_t'(k_imag_reg));
            REG_MAX_ITER: prdata = DATA_W'(max_iter_reg);
            default:      prdata = '0;
        endcase
    end

    mjei_mult u_mult (
        .aclk    (aclk),
        .mul_op  (mul_op),
        .product (product)
    );

    // Norm test and next z, evaluated in the update cycle (product holds re*im)
    assign norm    = {1'b0, rr_reg} + {1'b0, ii_reg};
    assign escaped = norm > NORM_LIMIT;
    assign re_part = $signed({{(SUM_W - PROD_W + FRAC_W){1'b0}}, rr_reg[PROD_W-1:FRAC_W]})
                   - $signed({{(SUM_W - PROD_W + FRAC_W){1'b0}}, ii_reg[PROD_W-1:FRAC_W]});
    assign im_abs  = $signed({{(SUM_W - PROD_W + FRAC_W - 1){1'b0}},
                              product[PROD_W-1:FRAC_W-1]});
    assign im_part = (z_re_reg[COORD_W-1] ^ z_im_reg[COORD_W-1]) ? -im_abs : im_abs;
    assign sum_re  = re_part + widen(k_real_reg) + widen(prior_re_reg);
    assign sum_im  = im_part + widen(k_imag_reg) + widen(prior_im_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_CHECK;
            ST_CHECK:  state_next = (step_cnt_reg == max_iter_reg) ? ST_FINISH : ST_MUL_RR;
            ST_MUL_RR: state_next = ST_MUL_II;
            ST_MUL_II: state_next = ST_MUL_RI;
            ST_MUL_RI: state_next = ST_UPDATE;
            ST_UPDATE: state_next = escaped ? ST_FINISH : ST_CHECK;
            ST_FINISH: if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and multiplier operand select
    always_comb begin
        s_ready     = 1'b0;
        out_load    = 1'b0;
        mul_op.op_a = mag_re_reg;
        mul_op.op_b = mag_re_reg;
        case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_MUL_II: begin
                mul_op.op_a = mag_im_reg;
                mul_op.op_b = mag_im_reg;
            end
            ST_MUL_RI: begin
                mul_op.op_a = mag_re_reg;
                mul_op.op_b = mag_im_reg;
            end
            ST_FINISH: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_valid && s_ready) begin
                step_cnt_reg <= '0;
            end else if (state_reg == ST_UPDATE && !escaped) begin
                step_cnt_reg <= step_cnt_reg + iter_t'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Iteration datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    z_re_reg     <= s_pixel_re;
                    z_im_reg     <= s_pixel_im;
                    prior_re_reg <= s_pixel_re;
                    prior_im_reg <= s_pixel_im;
                    inside_reg   <= 1'b0;
                end
            end
            ST_CHECK: begin
                inside_reg <= (step_cnt_reg == max_iter_reg);
                mag_re_reg <= mag_of(z_re_reg);
                mag_im_reg <= mag_of(z_im_reg);
            end
            ST_MUL_II: rr_reg <= product;
            ST_MUL_RI: ii_reg <= product;
            ST_UPDATE: begin
                if (!escaped) begin
                    prior_re_reg <= z_re_reg;
                    prior_im_reg <= z_im_reg;
                    z_re_reg     <= clamp(sum_re);
                    z_im_reg     <= clamp(sum_im);
                end
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_count_reg     <= step_cnt_reg;
            m_inside_reg    <= inside_reg;
            m_escape_re_reg <= inside_reg ? '0 : z_re_reg;
            m_escape_im_reg <= inside_reg ? '0 : z_im_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_iteration_count = m_count_reg;
    assign m_inside_set      = m_inside_reg;
    assign m_escape_re       = m_escape_re_reg;
    assign m_escape_im       = m_escape_im_reg;

    // Checks
    `MJEI_ASSERT_IMPL(a_inside_zero, m_valid_reg && m_inside_reg, m_escape_re_reg == '0 && m_escape_im_reg == '0)
    `MJEI_ASSERT_IMPL(a_inside_count, m_valid_reg && m_inside_reg, m_count_reg == max_iter_reg)
    `MJEI_ASSERT_IMPL(a_step_bound, state_reg != ST_IDLE, step_cnt_reg <= max_iter_reg)
    `MJEI_ASSERT_NEXT(a_accept_check, s_valid && s_ready, state_reg == ST_CHECK && step_cnt_reg == '0)

endmodule
